FILE: rtl/anh_pkg.sv
// Package with the widths, constants, types and helper functions of the archive name hash.
`timescale 1ns / 1ps
`default_nettype none

package anh_pkg;

    localparam int CHAR_W           = 8;
    localparam int LEN_W            = 8;
    localparam int HALF_W           = LEN_W - 1;
    localparam int HASH_W           = 32;
    localparam int ROT_W            = $clog2(HASH_W);
    localparam int MAX_NAME_LEN_DEF = 255;

    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 8'h20;
    localparam logic              FOLD_CASE_RST = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic [HALF_W-1:0] half;
        logic              last;
    } t_item_stage;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic fold);
        logic [CHAR_W-1:0] res;
        res = c;
        if (fold && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
            res = c + ASCII_CASE_OFS;
        end
        return res;
    endfunction

    function automatic logic [HASH_W-1:0] sext_char(input logic [CHAR_W-1:0] c);
        return {{(HASH_W - CHAR_W){c[CHAR_W-1]}}, c};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/anh_if.sv
// Channel interfaces for the configuration write, the character items and the hash results.
`timescale 1ns / 1ps
`default_nettype none

interface anh_cfg_if;
    logic valid;
    logic ready;
    logic fold_case;

    modport source (output valid, output fold_case, input ready);
    modport sink (input valid, input fold_case, output ready);
endinterface

interface anh_item_if;
    logic                        valid;
    logic                        ready;
    logic [anh_pkg::CHAR_W-1:0]  char_byte;
    logic [anh_pkg::LEN_W-1:0]   name_length;
    logic                        last_char;

    modport source (output valid, output char_byte, output name_length,
                    output last_char, input ready);
    modport sink (input valid, input char_byte, input name_length,
                  input last_char, output ready);
endinterface

interface anh_result_if;
    logic                        valid;
    logic                        ready;
    logic [anh_pkg::HASH_W-1:0]  hash_first;
    logic [anh_pkg::HASH_W-1:0]  hash_second;

    modport source (output valid, output hash_first, output hash_second, input ready);
    modport sink (input valid, input hash_first, input hash_second, output ready);
endinterface

`default_nettype wire

FILE: rtl/archive_name_hash_top.sv
// Top level of the streaming archive file name hash (XOR-shift and XOR-rotate pair).
//
//  Channel   Direction  Payload                              Transaction
//  i_cfg     in         fold_case                            valid & ready
//  i_item    in         char_byte, name_length, last_char    valid & ready
//  o_result  out        hash_first, hash_second              valid & ready
//
// One character is taken per cycle unless stalled; each result is registered.
// The input register feeds one hash stage whose state registers close the loop.
// Reset is synchronous and clears the position, both hashes and all valid flags.
// A waiting result stalls only a last character; other characters keep flowing.
`timescale 1ns / 1ps
`default_nettype none

module archive_name_hash_top #(
    parameter int MAX_NAME_LEN = anh_pkg::MAX_NAME_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    anh_cfg_if.sink         i_cfg,
    anh_item_if.sink        i_item,
    anh_result_if.source    o_result
);

    localparam int PW = $clog2(MAX_NAME_LEN + 1);
    localparam int CW = (PW > anh_pkg::HALF_W) ? PW : anh_pkg::HALF_W;

    logic                         r_fold_case;
    logic                         r_s1_valid;
    anh_pkg::t_item_stage         r_s1;
    logic [PW-1:0]                r_pos;
    logic [PW-1:0]                n_pos;
    logic [anh_pkg::HASH_W-1:0]   r_first;
    logic [anh_pkg::HASH_W-1:0]   n_first;
    logic [anh_pkg::HASH_W-1:0]   r_acc;
    logic [anh_pkg::HASH_W-1:0]   n_acc;
    logic                         r_out_valid;
    logic [anh_pkg::HASH_W-1:0]   r_hash_first;
    logic [anh_pkg::HASH_W-1:0]   r_hash_second;

    logic                         s1_advance;
    logic                         item_accept;
    logic [CW-1:0]                pos_ext;
    logic [CW-1:0]                half_ext;
    logic                         in_first;
    logic [1:0]                   sec_slot;
    logic [anh_pkg::HASH_W-1:0]   word;
    logic [anh_pkg::HASH_W-1:0]   first_term;
    logic [anh_pkg::HASH_W-1:0]   sec_term;
    logic [anh_pkg::HASH_W-1:0]   sec_mix;
    logic [2*anh_pkg::HASH_W-1:0] sec_rot;

    assign i_cfg.ready = 1'b1;

    assign s1_advance   = r_s1_valid && (!r_s1.last || !r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || s1_advance;
    assign item_accept  = i_item.valid && i_item.ready;

    assign pos_ext    = CW'(r_pos);
    assign half_ext   = CW'(r_s1.half);
    assign in_first   = pos_ext < half_ext;
    assign sec_slot   = pos_ext[1:0] - half_ext[1:0];
    assign word       = anh_pkg::sext_char(r_s1.char_byte);
    assign first_term = word << {pos_ext[1:0], 3'b000};
    assign sec_term   = word << {sec_slot, 3'b000};
    assign sec_mix    = r_acc ^ sec_term;
    assign sec_rot    = {sec_mix, sec_mix} >> sec_term[anh_pkg::ROT_W-1:0];

    always_comb begin
        n_first = r_first;
        n_acc   = r_acc;
        n_pos   = r_pos;
        if (in_first) begin
            n_first = r_first ^ first_term;
        end else begin
            n_acc = sec_rot[anh_pkg::HASH_W-1:0];
        end
        if (r_pos < PW'(MAX_NAME_LEN)) begin
            n_pos = r_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_case <= anh_pkg::FOLD_CASE_RST;
        end else if (i_cfg.valid) begin
            r_fold_case <= i_cfg.fold_case;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (item_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_accept) begin
            r_s1.char_byte <= anh_pkg::fold_char(i_item.char_byte, r_fold_case);
            r_s1.half      <= i_item.name_length[anh_pkg::LEN_W-1:1];
            r_s1.last      <= i_item.last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_first <= '0;
            r_acc   <= '0;
        end else if (s1_advance) begin
            if (r_s1.last) begin
                r_pos   <= '0;
                r_first <= '0;
                r_acc   <= '0;
            end else begin
                r_pos   <= n_pos;
                r_first <= n_first;
                r_acc   <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1.last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1.last) begin
            r_hash_first  <= n_first;
            r_hash_second <= n_acc;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.hash_first  = r_hash_first;
    assign o_result.hash_second = r_hash_second;

endmodule

`default_nettype wire

FILE: rtl/anh_checker.sv
// Port-level checker for the archive name hash, with its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module anh_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [anh_pkg::HASH_W-1:0]  i_hash_first,
    input logic [anh_pkg::HASH_W-1:0]  i_hash_second,
    input logic                        i_cfg_ready
);

    // A new result can only come from an earlier last character transaction.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result appeared without a last character transaction");

    // A free output side must never hold back the input side.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while the output side was ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before its transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_hash_first) && $stable(i_hash_second)))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration write was refused");

endmodule

bind archive_name_hash_top anh_checker u_anh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_in_last     (i_item.last_char),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_hash_first  (o_result.hash_first),
    .i_hash_second (o_result.hash_second),
    .i_cfg_ready   (i_cfg.ready)
);

`default_nettype wire
